@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define SFQ_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("sfq assertion failed");

// checked at every edge
`define SFQ_ASSERT_ALWAYS(name, prop) \
	name: assert property (@(posedge clk) prop) \
		else $error("sfq assertion failed");

`endif

@@ rtl/sfq_pkg.sv @@
`timescale 1ns / 1ps
package sfq_pkg;

	typedef enum logic [3:0] {
		CMD_PUSH     = 4'd0,
		CMD_POP      = 4'd1,
		CMD_PEEK     = 4'd2,
		CMD_EDIT     = 4'd3,
		CMD_REMOVE   = 4'd4,
		CMD_EVENS    = 4'd5,
		CMD_CONTAINS = 4'd6,
		CMD_DEDUP    = 4'd7,
		CMD_CLEAR    = 4'd8
	} cmd_t;

	localparam logic [1:0] ERR_OK    = 2'd0;
	localparam logic [1:0] ERR_EMPTY = 2'd1;
	localparam logic [1:0] ERR_FULL  = 2'd2;

	typedef struct packed {
		logic [3:0]         cmd;
		logic signed [31:0] value;
		logic signed [31:0] new_value;
	} cmd_word_t;

	typedef struct packed {
		logic signed [31:0] data;
		logic               flag;
		logic [1:0]         error;
		logic [6:0]         count;
	} res_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HEAD,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_INNER_RD,
		ST_INNER_CHK,
		ST_RESP
	} state_t;

endpackage

@@ rtl/sfq_mem.sv @@
`timescale 1ns / 1ps
module sfq_mem
	import sfq_pkg::*;
#(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  logic [DATA_WIDTH-1:0] wdata,
	input  logic                  re,
	input  logic [AW-1:0]         raddr,
	output logic [DATA_WIDTH-1:0] rdata
);

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/sfq_ctrl.sv @@
`timescale 1ns / 1ps
module sfq_ctrl
	import sfq_pkg::*;
#(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	input  cmd_word_t             cmd_word,
	output logic                  result_valid,
	input  logic                  result_ready,
	output res_word_t             result,
	output logic                  we,
	output logic [AW-1:0]         waddr,
	output logic [DATA_WIDTH-1:0] wdata,
	output logic                  re,
	output logic [AW-1:0]         raddr,
	input  logic [DATA_WIDTH-1:0] rdata
);

	state_t                state_q, state_d;
	logic [AW-1:0]         head_q, head_d;
	logic [CW-1:0]         cnt_q, cnt_d;
	logic [3:0]            cmd_q, cmd_d;
	logic [DATA_WIDTH-1:0] key_q, key_d;
	logic [DATA_WIDTH-1:0] repl_q, repl_d;
	logic [DATA_WIDTH-1:0] cur_q, cur_d;
	logic [CW-1:0]         i_q, i_d;
	logic [CW-1:0]         j_q, j_d;
	logic [CW-1:0]         kept_q, kept_d;
	logic                  flag_q, flag_d;
	logic                  matched_q, matched_d;
	logic [31:0]           data_q, data_d;
	logic [1:0]            err_q, err_d;

	logic [63:0]           key_ext, repl_ext;

	// wrap head + offset into the ring
	function automatic logic [AW-1:0] slot(input logic [AW-1:0] b, input logic [CW-1:0] o);
		logic [CW:0] s;
		s = (CW+1)'(b) + (CW+1)'(o);
		if (s >= (CW+1)'(DEPTH)) begin
			s = s - (CW+1)'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	assign key_ext  = 64'($signed(cmd_word.value));
	assign repl_ext = 64'($signed(cmd_word.new_value));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q     <= cmd_d;
		key_q     <= key_d;
		repl_q    <= repl_d;
		cur_q     <= cur_d;
		i_q       <= i_d;
		j_q       <= j_d;
		kept_q    <= kept_d;
		flag_q    <= flag_d;
		matched_q <= matched_d;
		data_q    <= data_d;
		err_q     <= err_d;
	end

	always_comb begin
		logic [63:0]           rd_ext;
		logic [CW-1:0]         i_inc;
		logic [CW-1:0]         j_inc;
		logic                  last_i;
		logic                  do_keep;
		logic                  do_adv;
		logic                  drop;
		logic [DATA_WIDTH-1:0] keep_val;

		state_d   = state_q;
		head_d    = head_q;
		cnt_d     = cnt_q;
		cmd_d     = cmd_q;
		key_d     = key_q;
		repl_d    = repl_q;
		cur_d     = cur_q;
		i_d       = i_q;
		j_d       = j_q;
		kept_d    = kept_q;
		flag_d    = flag_q;
		matched_d = matched_q;
		data_d    = data_q;
		err_d     = err_q;
		we        = 1'b0;
		waddr     = slot(head_q, cnt_q);
		wdata     = key_q;
		re        = 1'b0;
		raddr     = slot(head_q, i_q);

		rd_ext   = 64'($signed(rdata));
		i_inc    = i_q + CW'(1);
		j_inc    = j_q + CW'(1);
		last_i   = (i_inc == cnt_q);
		do_keep  = 1'b0;
		do_adv   = 1'b0;
		drop     = 1'b0;
		keep_val = rdata;

		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_d     = cmd_word.cmd;
					key_d     = key_ext[DATA_WIDTH-1:0];
					repl_d    = repl_ext[DATA_WIDTH-1:0];
					flag_d    = 1'b0;
					err_d     = ERR_OK;
					data_d    = '0;
					i_d       = '0;
					kept_d    = '0;
					matched_d = 1'b0;
					state_d   = ST_RESP;
					case (cmd_word.cmd)
						CMD_PUSH: begin
							if (cnt_q == CW'(DEPTH)) begin
								err_d = ERR_FULL;
							end else begin
								we     = 1'b1;
								waddr  = slot(head_q, cnt_q);
								wdata  = key_ext[DATA_WIDTH-1:0];
								cnt_d  = cnt_q + CW'(1);
								flag_d = 1'b1;
							end
						end
						CMD_POP, CMD_PEEK: begin
							if (cnt_q == '0) begin
								err_d = ERR_EMPTY;
							end else begin
								re      = 1'b1;
								raddr   = head_q;
								state_d = ST_HEAD;
							end
						end
						CMD_EDIT, CMD_REMOVE, CMD_EVENS, CMD_CONTAINS, CMD_DEDUP: begin
							if (cnt_q != '0) begin
								state_d = ST_SCAN_RD;
							end
						end
						CMD_CLEAR: begin
							flag_d = (cnt_q != '0);
							cnt_d  = '0;
							head_d = '0;
						end
						default: begin
						end
					endcase
				end
			end
			ST_HEAD: begin
				data_d  = rd_ext[31:0];
				flag_d  = 1'b1;
				state_d = ST_RESP;
				if (cmd_q == CMD_POP) begin
					head_d = slot(head_q, CW'(1));
					cnt_d  = cnt_q - CW'(1);
				end
			end
			ST_SCAN_RD: begin
				re      = 1'b1;
				raddr   = slot(head_q, i_q);
				state_d = ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				case (cmd_q)
					CMD_EDIT, CMD_CONTAINS: begin
						if (rdata == key_q) begin
							if (cmd_q == CMD_EDIT) begin
								we    = 1'b1;
								waddr = slot(head_q, i_q);
								wdata = repl_q;
							end
							flag_d  = 1'b1;
							state_d = ST_RESP;
						end else if (last_i) begin
							state_d = ST_RESP;
						end else begin
							i_d     = i_inc;
							state_d = ST_SCAN_RD;
						end
					end
					CMD_DEDUP: begin
						cur_d = rdata;
						if (last_i) begin
							do_keep = 1'b1;
							do_adv  = 1'b1;
						end else begin
							j_d     = i_inc;
							state_d = ST_INNER_RD;
						end
					end
					default: begin
						if (cmd_q == CMD_REMOVE) begin
							drop = !matched_q && (rdata == key_q);
						end else begin
							drop = !rdata[0];
						end
						if (drop) begin
							flag_d    = 1'b1;
							matched_d = 1'b1;
						end else begin
							do_keep = 1'b1;
						end
						do_adv = 1'b1;
					end
				endcase
			end
			ST_INNER_RD: begin
				re      = 1'b1;
				raddr   = slot(head_q, j_q);
				state_d = ST_INNER_CHK;
			end
			ST_INNER_CHK: begin
				keep_val = cur_q;
				if (rdata == cur_q) begin
					// a later copy exists: drop this one
					flag_d = 1'b1;
					do_adv = 1'b1;
				end else if (j_inc == cnt_q) begin
					do_keep = 1'b1;
					do_adv  = 1'b1;
				end else begin
					j_d     = j_inc;
					state_d = ST_INNER_RD;
				end
			end
			ST_RESP: begin
				if (result_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// survivors are written back in place, never ahead of the read pointer
		if (do_keep) begin
			we     = 1'b1;
			waddr  = slot(head_q, kept_q);
			wdata  = keep_val;
			kept_d = kept_q + CW'(1);
		end
		if (do_adv) begin
			if (last_i) begin
				cnt_d   = kept_d;
				state_d = ST_RESP;
			end else begin
				i_d     = i_inc;
				state_d = ST_SCAN_RD;
			end
		end
	end

	assign cmd_stall    = (state_q != ST_IDLE);
	assign result_valid = (state_q == ST_RESP);
	assign result.data  = data_q;
	assign result.flag  = flag_q;
	assign result.error = err_q;
	assign result.count = 7'(cnt_q);

endmodule

@@ rtl/searchable_fifo_queue.sv @@
// Push, clear and unused codes need no memory read; pop and peek first read the head entry.
// Edit, contains, remove match and remove evens: a read state and a check state per entry walked.
// Dedupe: per entry walked, a further read and check for each later entry compared.
// Throughput is bound by the single read port of the entry memory; one word at a time.
// A finished word sits in an output register so the next word is accepted meanwhile.
// Reset (arst_n low, asynchronous) empties the queue; the entry memory is not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module searchable_fifo_queue
	import sfq_pkg::*;
#(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  cmd_word_t cmd_word,
	output logic      res_valid,
	input  logic      res_stall,
	output res_word_t res_word
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic                  we;
	logic [AW-1:0]         waddr;
	logic [DATA_WIDTH-1:0] wdata;
	logic                  re;
	logic [AW-1:0]         raddr;
	logic [DATA_WIDTH-1:0] rdata;

	logic                  ctrl_valid;
	logic                  out_free;
	res_word_t             ctrl_res;
	logic                  out_valid_q;
	res_word_t             out_q;

	assign out_free = !out_valid_q || !res_stall;

	sfq_ctrl #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.cmd_word     (cmd_word),
		.result_valid (ctrl_valid),
		.result_ready (out_free),
		.result       (ctrl_res),
		.we           (we),
		.waddr        (waddr),
		.wdata        (wdata),
		.re           (re),
		.raddr        (raddr),
		.rdata        (rdata)
	);

	sfq_mem #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= ctrl_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && ctrl_valid) begin
			out_q <= ctrl_res;
		end
	end

	assign res_valid = out_valid_q;
	assign res_word  = out_q;

	`SFQ_ASSERT(a_busy_after_accept, (cmd_valid && !cmd_stall) |=> cmd_stall)
	`SFQ_ASSERT(a_err_no_flag, (res_valid && res_word.error != ERR_OK) |-> !res_word.flag)
	`SFQ_ASSERT(a_err_no_data, (res_valid && res_word.error != ERR_OK) |-> (res_word.data == '0))
	`SFQ_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !res_valid)

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
module tb;
	import sfq_pkg::*;

	localparam int QDEPTH = 64;

	logic      clk;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_stall;
	cmd_word_t cmd_word;
	logic      res_valid;
	logic      res_stall;
	res_word_t res_word;

	searchable_fifo_queue uut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd_word(cmd_word),
		.res_valid(res_valid), .res_stall(res_stall), .res_word(res_word)
	);

	// shadow of the queue contents, kept in order from the head
	logic [31:0] shadow_q[$];
	res_word_t   pending_res[$];
	int          errors = 0;
	bit          stim_done = 0;
	bit          hold_res = 0;
	bit          no_idle = 0;

	typedef struct {
		cmd_word_t w;
		bit        has_exp;
		res_word_t exp;
	} dir_row_t;

	function automatic res_word_t qmodel_step(cmd_word_t w);
		res_word_t   r;
		logic [31:0] kept[$];
		bit          hit;
		int          i, j;
		r = '0;
		hit = 0;
		case (w.cmd)
			CMD_PUSH: begin
				if (shadow_q.size() >= QDEPTH) r.error = ERR_FULL;
				else begin
					shadow_q.push_back(w.value);
					r.flag = 1;
				end
			end
			CMD_POP, CMD_PEEK: begin
				if (shadow_q.size() == 0) r.error = ERR_EMPTY;
				else begin
					r.data = shadow_q[0];
					r.flag = 1;
					if (w.cmd == CMD_POP) void'(shadow_q.pop_front());
				end
			end
			CMD_EDIT: begin
				for (i = 0; i < shadow_q.size(); i++)
					if (!hit && shadow_q[i] == w.value) begin
						shadow_q[i] = w.new_value;
						hit = 1;
					end
				r.flag = hit;
			end
			CMD_CONTAINS: begin
				foreach (shadow_q[k]) if (shadow_q[k] == w.value) hit = 1;
				r.flag = hit;
			end
			CMD_REMOVE, CMD_EVENS, CMD_DEDUP: begin
				for (i = 0; i < shadow_q.size(); i++) begin
					bit drop;
					drop = 0;
					if (w.cmd == CMD_REMOVE) begin
						if (!hit && shadow_q[i] == w.value) drop = 1;
					end else if (w.cmd == CMD_EVENS) begin
						drop = !shadow_q[i][0];
					end else begin
						for (j = i + 1; j < shadow_q.size(); j++)
							if (shadow_q[j] == shadow_q[i]) drop = 1;
					end
					if (drop) hit = 1;
					else kept.push_back(shadow_q[i]);
				end
				shadow_q = kept;
				r.flag = hit;
			end
			CMD_CLEAR: begin
				r.flag = shadow_q.size() != 0;
				shadow_q.delete();
			end
			default: ;
		endcase
		r.count = 7'(shadow_q.size());
		return r;
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	task automatic send_word(cmd_word_t w);
		while (!no_idle && $urandom_range(99) < 21) begin
			cmd_valid <= 0;
			@(negedge clk);
		end
		cmd_valid <= 1;
		cmd_word <= w;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		pending_res.push_back(qmodel_step(w));
		@(negedge clk);
	endtask

	function automatic cmd_word_t mk(cmd_t c, logic [31:0] v, logic [31:0] nv);
		cmd_word_t w;
		w.cmd = c;
		w.value = v;
		w.new_value = nv;
		return w;
	endfunction

	function automatic logic [31:0] rand_val(int pool);
		if (pool > 0) return $urandom_range(pool);
		return $urandom;
	endfunction

	// stimulus
	initial begin
		dir_row_t  rows[$];
		dir_row_t  row;
		res_word_t e;
		int        n, pool;
		cmd_valid = 0;
		cmd_word = '0;
		arst_n = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		e = '0; e.error = ERR_EMPTY;
		row.w = mk(CMD_POP, 0, 0); row.has_exp = 1; row.exp = e; rows.push_back(row);
		row.w = mk(CMD_PEEK, 0, 0); rows.push_back(row);
		e = '0;
		row.w = mk(CMD_CLEAR, 0, 0); row.exp = e; rows.push_back(row);
		row.w = mk(CMD_DEDUP, 0, 0); rows.push_back(row);
		row.w = mk(CMD_EVENS, 0, 0); rows.push_back(row);
		row.w = mk(CMD_CONTAINS, 0, 0); rows.push_back(row);
		row.w = mk(cmd_t'(4'd15), 32'hffff_ffff, 32'hffff_ffff); rows.push_back(row);
		row.has_exp = 0;
		row.w = mk(CMD_PUSH, 32'h8000_0000, 0); rows.push_back(row);
		row.w = mk(CMD_PUSH, 32'h7fff_ffff, 0); rows.push_back(row);
		row.w = mk(CMD_PUSH, 32'h8000_0000, 0); rows.push_back(row);
		row.w = mk(CMD_PUSH, 32'hffff_ffff, 0); rows.push_back(row);
		row.w = mk(CMD_PUSH, 0, 0); rows.push_back(row);
		row.w = mk(CMD_CONTAINS, 32'h7fff_ffff, 0); rows.push_back(row);
		row.w = mk(CMD_CONTAINS, 5, 0); rows.push_back(row);
		row.w = mk(CMD_EDIT, 32'hffff_ffff, 32'h8000_0001); rows.push_back(row);
		row.w = mk(CMD_EDIT, 9, 1); rows.push_back(row);
		row.w = mk(CMD_DEDUP, 0, 0); rows.push_back(row);
		row.w = mk(CMD_DEDUP, 0, 0); rows.push_back(row);
		row.w = mk(CMD_REMOVE, 9, 0); rows.push_back(row);
		row.w = mk(CMD_REMOVE, 32'h7fff_ffff, 0); rows.push_back(row);
		row.w = mk(CMD_EVENS, 0, 0); rows.push_back(row);
		row.w = mk(CMD_PEEK, 0, 0); rows.push_back(row);
		row.w = mk(CMD_POP, 0, 0); rows.push_back(row);
		row.w = mk(cmd_t'(4'd9), 0, 0); rows.push_back(row);
		row.w = mk(CMD_CLEAR, 0, 0); rows.push_back(row);

		foreach (rows[i]) begin
			send_word(rows[i].w);
			if (rows[i].has_exp && pending_res[$] !== rows[i].exp) begin
				$display("%0t directed row %0d: table %h, predictor %h",
					$time, i, rows[i].exp, pending_res[$]);
				errors++;
			end
		end

		// hold results off once, fill to full, then push over the top
		hold_res = 1;
		for (int i = 0; i < QDEPTH + 3; i++) send_word(mk(CMD_PUSH, $urandom, 0));
		hold_res = 0;
		for (int i = 0; i < 70; i++) send_word(mk(CMD_POP, 0, 0));

		n = 0;
		while (n < 900) begin
			cmd_word_t w;
			int r;
			no_idle = (n >= 400 && n < 500);
			pool = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 15);
			r = $urandom_range(99);
			if (r < 40) w = mk(CMD_PUSH, rand_val(pool), 0);
			else if (r < 55) w = mk(CMD_POP, 0, 0);
			else if (r < 60) w = mk(CMD_PEEK, 0, 0);
			else if (r < 67) w = mk(CMD_EDIT, rand_val(pool), $urandom);
			else if (r < 74) w = mk(CMD_REMOVE, rand_val(pool), 0);
			else if (r < 78) w = mk(CMD_EVENS, 0, 0);
			else if (r < 85) w = mk(CMD_CONTAINS, rand_val(pool), $urandom);
			else if (r < 92) w = mk(CMD_DEDUP, 0, 0);
			else if (r < 95) w = mk(CMD_CLEAR, 0, 0);
			else w = mk(cmd_t'(4'($urandom_range(9, 15))), $urandom, $urandom);
			send_word(w);
			n++;
		end
		cmd_valid <= 0;
		no_idle = 0;
		stim_done = 1;
	end

	// result side: random stall, one long hold when the queue fill starts
	initial begin
		bit held;
		held = 0;
		res_stall = 1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_res && !held) begin
				held = 1;
				res_stall <= 1;
				repeat (600) @(negedge clk);
			end
			res_stall <= !no_idle && ($urandom_range(99) < 21);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (pending_res.size() == 0) begin
				$display("%0t unexpected word %h", $time, res_word);
				errors++;
			end else begin
				res_word_t x;
				x = pending_res.pop_front();
				if (res_word.data !== x.data || res_word.flag !== x.flag ||
				    res_word.error !== x.error || res_word.count !== x.count) begin
					$display("%0t mismatch: expected %h actual %h", $time, x, res_word);
					errors++;
				end
			end
		end
	end

	initial begin
		wait (stim_done && pending_res.size() == 0);
		repeat (300) @(posedge clk);
		if (errors == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("Verification failed");
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/sfq_pkg.sv
rtl/sfq_mem.sv
rtl/sfq_ctrl.sv
rtl/searchable_fifo_queue.sv
sim/tb.sv
